// ===== sv/sedsc_pkg.sv =====
package sedsc_pkg;

  // Field widths
  localparam int unsigned TRACK_W = 16;
  localparam int unsigned MOVE_W  = 17;
  localparam int unsigned SUM_W   = 18;
  localparam int unsigned SIZE_W  = 17;

  // Stream word layout
  localparam int unsigned IN_TDATA_W  = 16;
  localparam int unsigned OUT_TDATA_W = 40;

  // Largest track count honored; larger disk sizes saturate to this
  localparam logic [SIZE_W-1:0] SIZE_MAX = 17'h10000;

  // Configuration register indexes
  typedef logic [1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_START_HEAD = 2'd0;
  localparam cfg_idx_t CFG_SWEEP_LEFT = 2'd1;
  localparam cfg_idx_t CFG_DISK_SIZE  = 2'd2;

  // Scheduler sequencer states
  typedef logic [1:0] seq_state_t;
  localparam seq_state_t ST_LOAD  = 2'd0;
  localparam seq_state_t ST_SCAN  = 2'd1;
  localparam seq_state_t ST_PUSH  = 2'd2;
  localparam seq_state_t ST_FLUSH = 2'd3;

endpackage

// ===== sv/scan_elevator_disk_scheduler_core.sv =====
// Channel   | Direction | Signals                              | Contents
// ----------+-----------+--------------------------------------+---------------------------------
// s_axis    | in        | tvalid, tready, tdata[15:0], tlast    | request_track; tlast = is_last
// m_axis    | out       | tvalid, tready, tdata[39:0], tuser,   | serviced_track, total_movement;
//           |           | tlast                                | tuser = is_disk_end, tlast = last
// cfg       | in        | cfg_valid_i, cfg_ready_o, cfg_addr_i, | 0 start_head, 1 sweep_left_first,
//           |           | cfg_data_i[16:0]                     | 2 disk_size
//
// Loading takes one request per cycle. Each visit then costs one selection pass over the
// stored requests through the single read port of the request memory, followed by a
// hand-off state that passes the visit on. The input is not ready while a batch is
// scheduled; a stalled output holds the sequencer in its hand-off state.
// Reset clears the served marks, the counters and the configuration registers; the request
// memory itself is not cleared, entries are read only after they are written.
module scan_elevator_disk_scheduler_core
  import sedsc_pkg::*;
#(
  parameter int unsigned MAX_REQUESTS = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // Request stream
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [15:0] request_track
  input  logic                   s_axis_tlast,
  // Visit stream
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // [15:0] serviced_track, [32:16] total_movement
  output logic                   m_axis_tuser,   // [0] is_disk_end
  output logic                   m_axis_tlast,
  // Configuration writes
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  cfg_idx_t               cfg_addr_i,
  input  logic [SIZE_W-1:0]      cfg_data_i
);

  localparam int unsigned CntW = $clog2(MAX_REQUESTS + 1);
  localparam int unsigned IdxW = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
  localparam logic [CntW-1:0] CntMax = CntW'(MAX_REQUESTS);

  // Configuration registers
  logic [TRACK_W-1:0] start_head_q;
  logic               sweep_left_q;
  logic [SIZE_W-1:0]  disk_size_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_head_q <= '0;
      sweep_left_q <= 1'b0;
      disk_size_q  <= SIZE_MAX;
    end else if (cfg_valid_i) begin
      unique case (cfg_addr_i)
        CFG_START_HEAD: start_head_q <= cfg_data_i[TRACK_W-1:0];
        CFG_SWEEP_LEFT: sweep_left_q <= cfg_data_i[0];
        CFG_DISK_SIZE:  disk_size_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cfg_ready_o = 1'b1;

  // Sequencer and datapath registers
  seq_state_t          state_q, state_d;
  logic [CntW-1:0]     count_q, count_d;
  logic [TRACK_W-1:0]  origin_q, origin_d;
  logic [TRACK_W-1:0]  end_q, end_d;
  logic                left_q, left_d;
  logic                pass_q, pass_d;
  logic [TRACK_W-1:0]  head_q, head_d;
  logic [SUM_W-1:0]    sum_q, sum_d;
  logic [MAX_REQUESTS-1:0] marks_q, marks_d;
  logic [CntW-1:0]     issue_q, issue_d;
  logic                cmp_vld_q, cmp_vld_d;
  logic [IdxW-1:0]     cmp_idx_q, cmp_idx_d;
  logic                found_q, found_d;
  logic [TRACK_W-1:0]  best_q, best_d;
  logic [IdxW-1:0]     pick_q, pick_d;
  logic [TRACK_W-1:0]  vis_track_q, vis_track_d;
  logic                vis_end_q, vis_end_d;
  logic                pend_vld_q, pend_vld_d;
  logic [TRACK_W-1:0]  pend_track_q, pend_track_d;
  logic [SUM_W-1:0]    pend_sum_q, pend_sum_d;
  logic                pend_end_q, pend_end_d;
  logic                out_vld_q, out_vld_d;
  logic [TRACK_W-1:0]  out_track_q, out_track_d;
  logic [MOVE_W-1:0]   out_sum_q, out_sum_d;
  logic                out_end_q, out_end_d;
  logic                out_last_q, out_last_d;

  // Request memory
  logic [TRACK_W-1:0] req_mem [MAX_REQUESTS];
  logic [TRACK_W-1:0] rd_data_q;
  logic               in_xfer;
  logic               mem_we;
  logic               mem_re;

  assign in_xfer = s_axis_tvalid && s_axis_tready;
  assign mem_we  = in_xfer && (count_q < CntMax);
  assign mem_re  = (state_q == ST_SCAN) && (issue_q < count_q);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      req_mem[count_q[IdxW-1:0]] <= s_axis_tdata[TRACK_W-1:0];
    end
    if (mem_re) begin
      rd_data_q <= req_mem[issue_q[IdxW-1:0]];
    end
  end

  // Saturated disk geometry from the live configuration
  logic [SIZE_W-1:0]  size_c;
  logic [SIZE_W-1:0]  end_wide_c;
  logic [TRACK_W-1:0] end_c;
  logic [TRACK_W-1:0] origin_c;

  always_comb begin
    if (disk_size_q == '0) begin
      size_c = SIZE_W'(1);
    end else if (disk_size_q > SIZE_MAX) begin
      size_c = SIZE_MAX;
    end else begin
      size_c = disk_size_q;
    end
    end_wide_c = size_c - SIZE_W'(1);
    end_c      = end_wide_c[TRACK_W-1:0];
    origin_c   = (start_head_q > end_c) ? end_c : start_head_q;
  end

  // Compare stage: stored request saturated to the disk end
  logic [TRACK_W-1:0] cand_c;
  logic               cand_ok_c;

  always_comb begin
    cand_c = (rd_data_q > end_q) ? end_q : rd_data_q;
    if (left_q) begin
      cand_ok_c = (cand_c < origin_q) && (!found_q || (cand_c > best_q));
    end else begin
      cand_ok_c = (cand_c > origin_q) && (!found_q || (cand_c < best_q));
    end
    cand_ok_c = cand_ok_c && cmp_vld_q && !marks_q[cmp_idx_q];
  end

  logic               out_free;
  logic               scan_done;
  logic [TRACK_W-1:0] next_track_c;
  logic [TRACK_W-1:0] dist_c;

  assign out_free  = !out_vld_q || m_axis_tready;
  assign scan_done = (issue_q == count_q) && !cmp_vld_q;

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    origin_d     = origin_q;
    end_d        = end_q;
    left_d       = left_q;
    pass_d       = pass_q;
    head_d       = head_q;
    sum_d        = sum_q;
    marks_d      = marks_q;
    issue_d      = issue_q;
    cmp_vld_d    = 1'b0;
    cmp_idx_d    = cmp_idx_q;
    found_d      = found_q;
    best_d       = best_q;
    pick_d       = pick_q;
    vis_track_d  = vis_track_q;
    vis_end_d    = vis_end_q;
    pend_vld_d   = pend_vld_q;
    pend_track_d = pend_track_q;
    pend_sum_d   = pend_sum_q;
    pend_end_d   = pend_end_q;
    out_vld_d    = out_vld_q && !m_axis_tready;
    out_track_d  = out_track_q;
    out_sum_d    = out_sum_q;
    out_end_d    = out_end_q;
    out_last_d   = out_last_q;
    next_track_c = best_q;
    dist_c       = '0;

    unique case (state_q)
      ST_LOAD: begin
        if (mem_we) begin
          count_d = count_q + CntW'(1);
        end
        if (in_xfer && s_axis_tlast) begin
          origin_d = origin_c;
          end_d    = end_c;
          left_d   = sweep_left_q;
          pass_d   = 1'b0;
          head_d   = origin_c;
          sum_d    = '0;
          marks_d  = '0;
          issue_d  = '0;
          found_d  = 1'b0;
          state_d  = ST_SCAN;
        end
      end

      ST_SCAN: begin
        // Issue reads in index order, compare one entry per cycle
        if (mem_re) begin
          issue_d   = issue_q + CntW'(1);
          cmp_vld_d = 1'b1;
          cmp_idx_d = issue_q[IdxW-1:0];
        end
        if (cand_ok_c) begin
          found_d = 1'b1;
          best_d  = cand_c;
          pick_d  = cmp_idx_q;
        end
        if (scan_done) begin
          if (found_q) begin
            next_track_c    = best_q;
            vis_end_d       = 1'b0;
            marks_d[pick_q] = 1'b1;
            state_d         = ST_PUSH;
          end else if (!pass_q) begin
            // Sweep reached its end: visit the disk end and turn around
            next_track_c = left_q ? '0 : end_q;
            vis_end_d    = 1'b1;
            pass_d       = 1'b1;
            left_d       = !left_q;
            state_d      = ST_PUSH;
          end else begin
            state_d = ST_FLUSH;
          end
          if (state_d == ST_PUSH) begin
            dist_c      = (next_track_c > head_q) ? next_track_c - head_q
                                                  : head_q - next_track_c;
            sum_d       = sum_q + SUM_W'(dist_c);
            head_d      = next_track_c;
            vis_track_d = next_track_c;
          end
        end
      end

      ST_PUSH: begin
        // Visits are held back one step so that the final one can be flagged
        if (!pend_vld_q || out_free) begin
          if (pend_vld_q) begin
            out_vld_d   = 1'b1;
            out_track_d = pend_track_q;
            out_sum_d   = pend_sum_q[MOVE_W-1:0];
            out_end_d   = pend_end_q;
            out_last_d  = 1'b0;
          end
          pend_vld_d   = 1'b1;
          pend_track_d = vis_track_q;
          pend_sum_d   = sum_q;
          pend_end_d   = vis_end_q;
          issue_d      = '0;
          found_d      = 1'b0;
          state_d      = ST_SCAN;
        end
      end

      ST_FLUSH: begin
        if (out_free) begin
          out_vld_d   = 1'b1;
          out_track_d = pend_track_q;
          out_sum_d   = pend_sum_q[MOVE_W-1:0];
          out_end_d   = pend_end_q;
          out_last_d  = 1'b1;
          pend_vld_d  = 1'b0;
          count_d     = '0;
          state_d     = ST_LOAD;
        end
      end

      default: state_d = ST_LOAD;
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_LOAD;
      count_q    <= '0;
      marks_q    <= '0;
      issue_q    <= '0;
      cmp_vld_q  <= 1'b0;
      found_q    <= 1'b0;
      pass_q     <= 1'b0;
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
      head_q     <= '0;
      sum_q      <= '0;
    end else begin
      state_q    <= state_d;
      count_q    <= count_d;
      marks_q    <= marks_d;
      issue_q    <= issue_d;
      cmp_vld_q  <= cmp_vld_d;
      found_q    <= found_d;
      pass_q     <= pass_d;
      pend_vld_q <= pend_vld_d;
      out_vld_q  <= out_vld_d;
      head_q     <= head_d;
      sum_q      <= sum_d;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    origin_q     <= origin_d;
    end_q        <= end_d;
    left_q       <= left_d;
    cmp_idx_q    <= cmp_idx_d;
    best_q       <= best_d;
    pick_q       <= pick_d;
    vis_track_q  <= vis_track_d;
    vis_end_q    <= vis_end_d;
    pend_track_q <= pend_track_d;
    pend_sum_q   <= pend_sum_d;
    pend_end_q   <= pend_end_d;
    out_track_q  <= out_track_d;
    out_sum_q    <= out_sum_d;
    out_end_q    <= out_end_d;
    out_last_q   <= out_last_d;
  end

  assign s_axis_tready = (state_q == ST_LOAD);
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {(OUT_TDATA_W - MOVE_W - TRACK_W)'(0), out_sum_q, out_track_q};
  assign m_axis_tuser  = out_end_q;
  assign m_axis_tlast  = out_last_q;

endmodule
